@@ rtl/core/swm_pkg.sv @@
// swm_pkg: shared constants and controller command type for the sliding window median.
// No dependencies.
`timescale 1ns / 1ps

package swm_pkg;

    localparam int WINDOW   = 50;
    localparam int DATA_W   = 16;
    localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int MID_HI   = WINDOW / 2;
    localparam int MID_LO   = ((WINDOW % 2) == 0) ? (WINDOW / 2 - 1) : (WINDOW / 2);

    typedef struct packed {
        logic capture;
        logic del;
        logic ins;
        logic med;
    } t_cmd;

endpackage

@@ rtl/core/sliding_window_median.sv @@
// Sliding window median: running median over the last WINDOW pulse-width samples.
// Each input transaction passes through capture, delete, insert and median steps to a result.
// A new transaction is taken only after the delete/insert sequence on the sorted register
// row and the median step; a waiting result holds the median step until it is taken.
// Reset: synchronous, active low; window reads as all zeros, no result pending.
// Depends on swm_pkg, swm_ctrl, swm_dpath, swm_ram.
`timescale 1ns / 1ps

module sliding_window_median
    import swm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [DATA_W-1:0] i_pulse_width,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_median_width
);

    t_cmd w_cmd;

    swm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    swm_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_pulse_width  (i_pulse_width),
        .o_median_width (o_median_width)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after input transaction");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without work in progress");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("reset did not clear control state");
`endif

endmodule

@@ rtl/core/swm_ram.sv @@
// swm_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module swm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                          i_clk,
    input  logic                                          i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_wr_addr,
    input  logic [WIDTH-1:0]                              i_wr_data,
    input  logic                                          i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_rd_addr,
    output logic [WIDTH-1:0]                              o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/swm_ctrl.sv @@
// swm_ctrl: sequencing state machine for the sliding window median.
// Depends on swm_pkg.
`timescale 1ns / 1ps

module swm_ctrl
    import swm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    input  logic i_stall,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL,
        S_INS,
        S_MED
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_load;

    assign w_load = (r_state == S_MED) && (!r_out_valid || !i_stall);

    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_valid;
        o_cmd.del     = (r_state == S_DEL);
        o_cmd.ins     = (r_state == S_INS);
        o_cmd.med     = w_load;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DEL;
                end
            end
            S_DEL: n_state = S_INS;
            S_INS: n_state = S_MED;
            S_MED: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

@@ rtl/core/swm_dpath.sv @@
// swm_dpath: arrival-order sample RAM, sorted register row and median register.
// Depends on swm_pkg and swm_ram.
`timescale 1ns / 1ps

module swm_dpath
    import swm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [DATA_W-1:0] i_pulse_width,
    output logic [DATA_W-1:0] o_median_width
);

    logic [PTR_W-1:0]  r_ptr;
    logic [CNT_W-1:0]  r_fill;
    logic [DATA_W-1:0] r_sample;
    logic [DATA_W-1:0] r_median;
    logic [DATA_W-1:0] r_sorted [WINDOW];
    logic [DATA_W-1:0] w_del    [WINDOW];
    logic [DATA_W-1:0] w_ins    [WINDOW];
    logic [WINDOW-1:0] w_gt;
    logic [DATA_W-1:0] w_rd_data;
    logic [DATA_W-1:0] w_old;
    logic              w_full;
    logic [DATA_W:0]   w_sum;

    swm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WINDOW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.del),
        .i_wr_addr (r_ptr),
        .i_wr_data (r_sample),
        .i_rd_en   (i_cmd.capture),
        .i_rd_addr (r_ptr),
        .o_rd_data (w_rd_data)
    );

    // slots not yet written still hold the reset zeros
    assign w_full = (r_fill == CNT_W'(WINDOW));
    assign w_old  = w_full ? w_rd_data : '0;

    // delete: first entry >= old is removed, upper entries move down
    // insert: top slot is the hole; entries above the sample move up
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        if (g < WINDOW - 1) begin : g_low
            assign w_del[g] = (r_sorted[g] >= w_old) ? r_sorted[g+1] : r_sorted[g];
            assign w_gt[g]  = (r_sorted[g] > r_sample);
        end else begin : g_top
            assign w_del[g] = r_sorted[g];
            assign w_gt[g]  = 1'b1;
        end
        if (g == 0) begin : g_first
            assign w_ins[g] = w_gt[g] ? r_sample : r_sorted[g];
        end else begin : g_rest
            assign w_ins[g] = w_gt[g] ? (w_gt[g-1] ? r_sorted[g-1] : r_sample)
                                      : r_sorted[g];
        end
    end

    assign w_sum = {1'b0, r_sorted[MID_LO]} + {1'b0, r_sorted[MID_HI]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_fill <= '0;
            for (int i = 0; i < WINDOW; i++) begin
                r_sorted[i] <= '0;
            end
        end else begin
            if (i_cmd.del) begin
                r_sorted <= w_del;
                r_ptr    <= (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;
                if (!w_full) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.ins) begin
                r_sorted <= w_ins;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_pulse_width;
        end
        if (i_cmd.med) begin
            r_median <= w_sum[DATA_W:1];
        end
    end

    assign o_median_width = r_median;

endmodule

@@ bench/tb_sliding_window_median.sv @@
// tb_sliding_window_median: self-checking bench for the running median block.
// Walks a directed table, then random segments, against its own window model.
// Depends on swm_pkg and sliding_window_median.
`timescale 1ns / 1ps

module tb_sliding_window_median;
    import swm_pkg::*;

    localparam int RANDOM_SAMPLES = 1300;
    localparam int DIR_ROWS       = 25;

    typedef enum int {
        MIX_FULL,
        MIX_NARROW,
        MIX_RAILS,
        MIX_FLAT
    } mix_t;

    typedef struct packed {
        logic [DATA_W-1:0] sample;
        logic              typed;
        logic [DATA_W-1:0] median;
    } dir_row_t;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic [DATA_W-1:0] i_pulse_width = '0;
    logic              i_stall       = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [DATA_W-1:0] o_median_width;

    logic [DATA_W-1:0] win_model [WINDOW];
    logic [DATA_W-1:0] median_q [$];
    dir_row_t          dir_rows [DIR_ROWS];

    bit calm           = 1'b0;
    int failures       = 0;
    int samples_sent   = 0;
    int medians_seen   = 0;
    int top_medians    = 0;

    sliding_window_median i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pulse_width  (i_pulse_width),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_median_width (o_median_width)
    );

    always #10 i_clk = ~i_clk;

    // Shift the sample into the model window and return the new median.
    function automatic logic [DATA_W-1:0] shift_in_median(input logic [DATA_W-1:0] s);
        logic [DATA_W-1:0] srt [WINDOW];
        logic [DATA_W-1:0] key;
        logic [DATA_W:0]   pair_sum;
        int                j;
        for (int i = WINDOW - 1; i > 0; i--) begin
            win_model[i] = win_model[i-1];
        end
        win_model[0] = s;
        srt = win_model;
        for (int i = 1; i < WINDOW; i++) begin
            key = srt[i];
            j   = i - 1;
            while (j >= 0 && srt[j] > key) begin
                srt[j+1] = srt[j];
                j--;
            end
            srt[j+1] = key;
        end
        if ((WINDOW % 2) == 0) begin
            pair_sum = {1'b0, srt[WINDOW/2-1]} + {1'b0, srt[WINDOW/2]};
            return pair_sum[DATA_W:1];
        end
        return srt[WINDOW/2];
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // One input transaction; the expectation is queued at the accepting edge.
    task automatic send_sample(input logic [DATA_W-1:0] s, input logic typed,
                               input logic [DATA_W-1:0] typed_median);
        int                gap;
        logic [DATA_W-1:0] predicted;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pulse_width <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = shift_in_median(s);
        median_q.push_back(typed ? typed_median : predicted);
        samples_sent++;
    endtask

    function automatic logic [DATA_W-1:0] mix_sample(input mix_t mode,
                                                     input logic [DATA_W-1:0] base,
                                                     input int bias);
        case (mode)
            MIX_NARROW: return base + DATA_W'($urandom_range(0, 15));
            MIX_RAILS:  return ($urandom_range(0, 99) < bias) ? '1 : '0;
            MIX_FLAT:   return ($urandom_range(0, 9) == 0) ? DATA_W'($urandom) : base;
            default:    return DATA_W'($urandom);
        endcase
    endfunction

    // Result side: random stall pattern.
    initial begin : stall_drive
        int run;
        forever begin
            run = pick_gap();
            if (run > 0) begin
                i_stall <= 1'b1;
                repeat (run) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        logic [DATA_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            medians_seen++;
            if (o_median_width == '1) top_medians++;
            if (median_q.size() == 0) begin
                $error("median_width: unexpected transaction, actual %0d", o_median_width);
                failures++;
            end else begin
                want = median_q.pop_front();
                if (o_median_width !== want) begin
                    $error("median_width: expected %0d, actual %0d", want, o_median_width);
                    failures++;
                end
            end
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        mix_t              mode;
        logic [DATA_W-1:0] base;
        int                bias;
        int                seg_len;
        int                random_sent;
        bit                drained;

        // Fewer than WINDOW/2 non-zero samples: the reset zeros hold the median at 0.
        dir_rows = '{
            '{16'hFFFF, 1'b1, 16'h0000}, '{16'h0000, 1'b1, 16'h0000},
            '{16'h0001, 1'b1, 16'h0000}, '{16'h8000, 1'b1, 16'h0000},
            '{16'h7FFF, 1'b1, 16'h0000}, '{16'h5555, 1'b1, 16'h0000},
            '{16'hAAAA, 1'b1, 16'h0000}, '{16'h00FF, 1'b1, 16'h0000},
            '{16'hFF00, 1'b1, 16'h0000}, '{16'h0F0F, 1'b1, 16'h0000},
            '{16'hF0F0, 1'b1, 16'h0000}, '{16'h3333, 1'b1, 16'h0000},
            '{16'hCCCC, 1'b1, 16'h0000}, '{16'h0002, 1'b1, 16'h0000},
            '{16'hFFFE, 1'b1, 16'h0000}, '{16'h1234, 1'b1, 16'h0000},
            '{16'hEDCB, 1'b1, 16'h0000}, '{16'h0100, 1'b1, 16'h0000},
            '{16'h4000, 1'b1, 16'h0000}, '{16'h2000, 1'b1, 16'h0000},
            '{16'h0800, 1'b1, 16'h0000}, '{16'h0010, 1'b1, 16'h0000},
            '{16'h0400, 1'b1, 16'h0000}, '{16'h0040, 1'b1, 16'h0000},
            '{16'h0003, 1'b0, 16'h0000}
        };
        for (int i = 0; i < WINDOW; i++) win_model[i] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            send_sample(dir_rows[r].sample, dir_rows[r].typed, dir_rows[r].median);
        end

        random_sent = 0;
        drained     = 1'b0;
        while (random_sent < RANDOM_SAMPLES) begin
            mode    = mix_t'($urandom_range(0, 3));
            base    = DATA_W'($urandom_range(0, 65535 - 15));
            bias    = $urandom_range(0, 100);
            seg_len = $urandom_range(10, 80);
            calm    = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < seg_len; k++) begin
                send_sample(mix_sample(mode, base, bias), 1'b0, '0);
                random_sent++;
            end
            if (!drained && random_sent >= RANDOM_SAMPLES / 2) begin
                // Hold off until the pipeline is empty, then restart from idle.
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (median_q.size() != 0) @(posedge i_clk);
                drained = 1'b1;
            end
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (median_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Sent %0d samples (%0d from the directed table), checked %0d medians,",
                 samples_sent, DIR_ROWS, medians_seen);
        $display("%0d of them at full scale; window of %0d, random stalls both sides.",
                 top_medians, WINDOW);
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/swm_pkg.sv
rtl/core/swm_ram.sv
rtl/core/swm_ctrl.sv
rtl/core/swm_dpath.sv
rtl/core/sliding_window_median.sv
bench/tb_sliding_window_median.sv
